/* rtl/llsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// llsr_pkg
// Shared types, codes and sizes for the least-loaded server registry.
// ----------------------------------------------------------------------------
package llsr_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int LOAD_BITS   = 10;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int TOTAL_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

    // operation codes
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_RELEASE    = 2'd2;
    localparam logic [1:0] OP_PICK       = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] server_port;
        logic [31:0] server_address;
    } request_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [31:0]          chosen_address;
        logic [15:0]          chosen_port;
        logic [LOAD_BITS-1:0] chosen_load;
        logic [TOTAL_W-1:0]   entries_in_use;
    } result_t;

    typedef struct packed {
        logic [15:0]          port;
        logic [31:0]          address;
        logic [LOAD_BITS-1:0] load;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       scan;
        logic       shift_init;
        logic       shift;
        logic       append;
        logic       release_one;
        logic       pick;
        logic       drop;
        logic       finish;
        logic [2:0] code;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       scan_done;
        logic       shift_done;
        logic       found;
        logic       full;
        logic       empty;
    } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/least_loaded_server_registry.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_server_registry
// Ordered server table with register, unregister, release and
// least-loaded pick; one result item per request item.
// ----------------------------------------------------------------------------
// A request item is taken at a rising edge where start is high and busy is
// low. Exactly one result item follows: it sits on result for a single cycle
// with done high and must be taken then, since the block cannot be held off.
// The time from acceptance to done grows with the number of registered
// servers, and an unregister adds a compaction pass over the entries that
// lie above the removed one. The scan reads one entry per cycle from the
// entry memory, and compaction moves one entry per cycle. Busy drops in the
// cycle done rises, so no new request is taken before the previous result.
// ----------------------------------------------------------------------------
module least_loaded_server_registry (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire llsr_pkg::request_t request,
    output logic                    done,
    output llsr_pkg::result_t       result
);

    llsr_pkg::dp_cmd_t  cmd;
    llsr_pkg::dp_stat_t stat;

    // sequence each item: capture, scan, decide, optional compaction, report
    llsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // hold the table, track match and minimum, drive the result register
    llsr_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

    // an accepted item keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting an item");

    // results are single-cycle strobes, never adjacent
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // entry count never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entries_in_use
                  <= llsr_pkg::TOTAL_W'(llsr_pkg::TABLE_DEPTH)))
        else $error("entries_in_use beyond table depth");

    // only a successful pick carries a chosen server
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != llsr_pkg::ST_OK)) |->
        ((result.chosen_port == '0) && (result.chosen_address == '0)
         && (result.chosen_load == '0)))
        else $error("chosen fields set on a failed operation");

endmodule
`default_nettype wire

/* rtl/llsr_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// llsr_dp
// Datapath: entry memory, scan/shift index, match and minimum trackers,
// entry count and the result register.
// ----------------------------------------------------------------------------
module llsr_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire llsr_pkg::request_t request,
    input  wire llsr_pkg::dp_cmd_t  cmd,
    output llsr_pkg::dp_stat_t      stat,
    output logic                    done,
    output llsr_pkg::result_t       result
);

    localparam int IDX_W   = llsr_pkg::IDX_W;
    localparam int TOTAL_W = llsr_pkg::TOTAL_W;

    llsr_pkg::entry_t mem [llsr_pkg::TABLE_DEPTH];

    // control state
    logic [TOTAL_W-1:0] idx_reg,   idx_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               pend_reg,  pend_next;
    logic               found_reg, found_next;
    logic               best_vld_reg, best_vld_next;
    logic               done_reg,  done_next;

    // payload
    llsr_pkg::request_t req_reg,   req_next;
    llsr_pkg::entry_t   rdata_reg;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    llsr_pkg::entry_t   match_reg, match_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    llsr_pkg::entry_t   best_reg, best_next;
    llsr_pkg::entry_t   chosen_reg, chosen_next;
    llsr_pkg::result_t  result_reg, result_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    llsr_pkg::entry_t   wdata;
    logic               more;

    assign more = (idx_reg != total_reg);

    always_comb
    begin
        idx_next       = idx_reg;
        total_next     = total_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        best_vld_next  = best_vld_reg;
        done_next      = cmd.finish;
        req_next       = req_reg;
        rd_idx_next    = idx_reg[IDX_W-1:0];
        match_idx_next = match_idx_reg;
        match_next     = match_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        chosen_next    = chosen_reg;
        result_next    = result_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = rdata_reg;

        if (cmd.capture)
        begin
            req_next      = request;
            idx_next      = '0;
            found_next    = 1'b0;
            best_vld_next = 1'b0;
            chosen_next   = '0;
        end

        // advance the read index one entry per cycle
        if ((cmd.scan || cmd.shift) && more)
        begin
            pend_next = 1'b1;
            idx_next  = idx_reg + TOTAL_W'(1);
        end

        if (cmd.scan && pend_reg)
        begin
            if (!found_reg && (rdata_reg.port == req_reg.server_port))
            begin
                found_next     = 1'b1;
                match_idx_next = rd_idx_reg;
                match_next     = rdata_reg;
            end
            // strict compare keeps the first entry holding the minimum
            if (!best_vld_reg || (rdata_reg.load < best_reg.load))
            begin
                best_vld_next = 1'b1;
                best_idx_next = rd_idx_reg;
                best_next     = rdata_reg;
            end
        end

        if (cmd.shift_init)
        begin
            idx_next = TOTAL_W'(match_idx_reg) + TOTAL_W'(1);
        end

        if (cmd.shift && pend_reg)
        begin
            we    = 1'b1;
            waddr = rd_idx_reg - IDX_W'(1);
            wdata = rdata_reg;
        end

        if (cmd.append)
        begin
            we            = 1'b1;
            waddr         = total_reg[IDX_W-1:0];
            wdata.port    = req_reg.server_port;
            wdata.address = req_reg.server_address;
            wdata.load    = '0;
            total_next    = total_reg + TOTAL_W'(1);
        end

        if (cmd.release_one)
        begin
            we    = 1'b1;
            waddr = match_idx_reg;
            wdata = match_reg;
            if (match_reg.load != '0)
            begin
                wdata.load = match_reg.load - llsr_pkg::LOAD_BITS'(1);
            end
        end

        if (cmd.pick)
        begin
            we    = 1'b1;
            waddr = best_idx_reg;
            wdata = best_reg;
            if (best_reg.load != llsr_pkg::LOAD_MAX)
            begin
                wdata.load = best_reg.load + llsr_pkg::LOAD_BITS'(1);
            end
            chosen_next = wdata;
        end

        if (cmd.drop)
        begin
            total_next = total_reg - TOTAL_W'(1);
        end

        if (cmd.finish)
        begin
            result_next.status         = cmd.code;
            result_next.chosen_address = chosen_reg.address;
            result_next.chosen_port    = chosen_reg.port;
            result_next.chosen_load    = chosen_reg.load;
            result_next.entries_in_use = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            total_reg    <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            total_reg    <= total_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            best_vld_reg <= best_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        match_idx_reg <= match_idx_next;
        match_reg     <= match_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        chosen_reg    <= chosen_next;
        result_reg    <= result_next;
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    assign stat.opcode     = req_reg.opcode;
    assign stat.scan_done  = !more && !pend_reg;
    assign stat.shift_done = !more && !pend_reg;
    assign stat.found      = found_reg;
    assign stat.full       = (total_reg == TOTAL_W'(llsr_pkg::TABLE_DEPTH));
    assign stat.empty      = (total_reg == '0);

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* rtl/llsr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// llsr_ctrl
// Controller: sequences capture, table scan, decision, compaction and result.
// ----------------------------------------------------------------------------
module llsr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire llsr_pkg::dp_stat_t stat,
    output logic                    busy,
    output llsr_pkg::dp_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] code_reg,  code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_FINISH;
                code_next  = llsr_pkg::ST_OK;
                unique case (stat.opcode)
                    llsr_pkg::OP_REGISTER:
                    begin
                        priority if (stat.found)
                            code_next = llsr_pkg::ST_DUP;
                        else if (stat.full)
                            code_next = llsr_pkg::ST_FULL;
                        else
                            cmd.append = 1'b1;
                    end
                    llsr_pkg::OP_UNREGISTER:
                    begin
                        if (!stat.found)
                        begin
                            code_next = llsr_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = S_SHIFT;
                        end
                    end
                    llsr_pkg::OP_RELEASE:
                    begin
                        if (!stat.found)
                            code_next = llsr_pkg::ST_NOTFOUND;
                        else
                            cmd.release_one = 1'b1;
                    end
                    llsr_pkg::OP_PICK:
                    begin
                        if (stat.empty)
                            code_next = llsr_pkg::ST_EMPTY;
                        else
                            cmd.pick = 1'b1;
                    end
                    default:
                    begin
                        code_next = llsr_pkg::ST_OK;
                    end
                endcase
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= llsr_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire
